/* rtl/core/ctcg_pkg.sv */
// Shared types and constants for the CTC greedy decoder core.
// No dependencies; imported by ctc_greedy_decoder_core.
package ctcg_pkg;

  localparam int MAX_CLASSES = 8192;
  localparam int MAX_STEPS   = 1024;
  localparam int SCORE_BITS  = 16;

  localparam int CLASS_BITS = $clog2(MAX_CLASSES);       // class index width
  localparam int STEP_BITS  = $clog2(MAX_STEPS);         // step counter width
  localparam int CFG_CBITS  = CLASS_BITS + 1;            // classes / dictionary reg
  localparam int CFG_SBITS  = STEP_BITS + 1;             // steps reg, token count
  localparam int CFG_DBITS  = CFG_CBITS;                 // config data bus
  localparam int TAG_BITS   = 64;
  localparam int SUM_BITS   = 27;
  localparam int DIV_STEPS  = SUM_BITS;
  localparam int ITER_BITS  = $clog2(DIV_STEPS);

  localparam logic signed [SUM_BITS:0] SUM_MAX = (28'sd1 <<< (SUM_BITS - 1)) - 28'sd1;
  localparam logic signed [SUM_BITS:0] SUM_MIN = -(28'sd1 <<< (SUM_BITS - 1));

  typedef enum logic [1:0] {
    REG_CLASSES    = 2'd0,
    REG_STEPS      = 2'd1,
    REG_DICTIONARY = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM
  } state_t;

  typedef enum logic {
    KIND_TOKEN   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    logic                         kind;
    logic [CLASS_BITS-1:0]        token_index;
    logic [TAG_BITS-1:0]          tag;
    logic signed [SCORE_BITS-1:0] mean;
    logic [CFG_SBITS-1:0]         count;
    logic                         last;
  } result_t;

endpackage

/* rtl/core/ctc_greedy_decoder_core.sv */
// CTC greedy decoder core: per-step argmax, blank/repeat/dictionary filtering,
// token stream and end-of-sequence summary. Depends on ctcg_pkg.

// The block takes one class score per clock while it is idle and the result
// queue has room for what that score can produce (one slot at a step end, two
// at a sequence end). No score is accepted after the one that closes a sequence
// until its summary is queued: the mean confidence comes from one shared
// subtract/compare unit doing restoring division in ST_DIV, one quotient bit per
// cycle; ST_SUM queues the summary. Results leave through a two-entry queue,
// so scores keep flowing while a token waits to be taken. No clearing pass
// follows reset; the block is ready as soon as reset drops.
module ctc_greedy_decoder_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [ctcg_pkg::CFG_DBITS-1:0]        cfg_data,
  // score stream
  input  logic                                  score_valid,
  output logic                                  score_ready,
  input  logic signed [ctcg_pkg::SCORE_BITS-1:0] score,
  input  logic [ctcg_pkg::TAG_BITS-1:0]         sequence_tag,
  // result stream
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic                                  kind,
  output logic [ctcg_pkg::CLASS_BITS-1:0]       token_index,
  output logic [ctcg_pkg::TAG_BITS-1:0]         tag_out,
  output logic signed [ctcg_pkg::SCORE_BITS-1:0] mean_confidence,
  output logic [ctcg_pkg::CFG_SBITS-1:0]        token_count,
  output logic                                  last
);
  import ctcg_pkg::*;

  // configuration
  logic [CFG_CBITS-1:0] cfg_classes;
  logic [CFG_SBITS-1:0] cfg_steps;
  logic [CFG_CBITS-1:0] cfg_dict;

  // decode state
  logic [CLASS_BITS-1:0]        class_counter;
  logic [STEP_BITS-1:0]         step_counter;
  logic signed [SCORE_BITS-1:0] top_score;
  logic [CLASS_BITS-1:0]        best_index;
  logic [CLASS_BITS-1:0]        previous_index;
  logic                         previous_valid;
  logic signed [SUM_BITS-1:0]   score_sum;
  logic [CFG_SBITS-1:0]         emitted_count;
  logic [TAG_BITS-1:0]          latched_tag;

  // divider
  logic [SUM_BITS-1:0]  div_quot;
  logic [CFG_SBITS-1:0] div_rem;
  logic [CFG_SBITS-1:0] div_den;
  logic                 div_neg;
  logic [ITER_BITS-1:0] div_iter;

  // result queue
  result_t    out_q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] q_cnt;

  state_t state, state_next;

  // ---------------------------------------------------------------
  // per-score datapath
  logic [CFG_CBITS-1:0]         n_classes;
  logic [CFG_SBITS-1:0]         n_steps;
  logic                         step_end, seq_end, first_score;
  logic signed [SCORE_BITS-1:0] cur_score;
  logic [CLASS_BITS-1:0]        cur_index;
  logic                         repeat_hit, keep;
  logic signed [SUM_BITS:0]     sum_wide;
  logic signed [SUM_BITS-1:0]   sum_new;
  logic [CFG_SBITS-1:0]         count_new;
  logic [TAG_BITS-1:0]          tag_now;
  logic [1:0]                   need;
  logic [2:0]                   q_after;
  logic                         accept;

  always_comb begin
    if (cfg_classes == '0)
      n_classes = CFG_CBITS'(1);
    else if (cfg_classes > CFG_CBITS'(MAX_CLASSES))
      n_classes = CFG_CBITS'(MAX_CLASSES);
    else
      n_classes = cfg_classes;

    if (cfg_steps == '0)
      n_steps = CFG_SBITS'(1);
    else if (cfg_steps > CFG_SBITS'(MAX_STEPS))
      n_steps = CFG_SBITS'(MAX_STEPS);
    else
      n_steps = cfg_steps;
  end

  assign step_end    = ({1'b0, class_counter} + CFG_CBITS'(1)) >= n_classes;
  assign seq_end     = step_end && (({1'b0, step_counter} + CFG_SBITS'(1)) >= n_steps);
  assign first_score = (class_counter == '0) && (step_counter == '0);
  assign tag_now     = first_score ? sequence_tag : latched_tag;

  always_comb begin
    if (class_counter == '0) begin
      cur_score = score;
      cur_index = '0;
    end else if (score > top_score) begin
      cur_score = score;
      cur_index = class_counter;
    end else begin
      cur_score = top_score;
      cur_index = best_index;
    end
  end

  assign repeat_hit = previous_valid && (cur_index == previous_index);
  assign keep       = step_end && (cur_index != '0) && !repeat_hit &&
                      ({1'b0, cur_index} < cfg_dict);

  always_comb begin
    sum_wide = (SUM_BITS + 1)'(score_sum) + (SUM_BITS + 1)'(cur_score);
    if (sum_wide > SUM_MAX)
      sum_wide = SUM_MAX;
    else if (sum_wide < SUM_MIN)
      sum_wide = SUM_MIN;
    sum_new   = keep ? sum_wide[SUM_BITS-1:0] : score_sum;
    count_new = emitted_count + CFG_SBITS'(keep);
  end

  // worst-case queue demand of the score now on the port
  assign need    = seq_end ? 2'd2 : (step_end ? 2'd1 : 2'd0);
  assign q_after = {1'b0, q_cnt} + {1'b0, need};

  // ---------------------------------------------------------------
  // shared subtract/compare unit, one quotient bit per cycle
  logic [CFG_SBITS:0]   rem_shift;
  logic [CFG_SBITS+1:0] rem_diff;
  logic                 rem_ge;

  assign rem_shift = {div_rem, div_quot[SUM_BITS-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, div_den};
  assign rem_ge    = !rem_diff[CFG_SBITS+1];

  // ---------------------------------------------------------------
  // sequencer
  logic sum_push;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && seq_end) state_next = ST_DIV;
      ST_DIV:  if (div_iter == ITER_BITS'(DIV_STEPS - 1)) state_next = ST_SUM;
      ST_SUM:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    score_ready = 1'b0;
    sum_push    = 1'b0;
    case (state)
      ST_IDLE: score_ready = (q_after <= 3'd2);
      ST_DIV:  score_ready = 1'b0;
      ST_SUM:  sum_push    = 1'b1;
      default: score_ready = 1'b0;
    endcase
  end

  assign accept    = score_valid && score_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // ---------------------------------------------------------------
  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_classes <= CFG_CBITS'(1);
      cfg_steps   <= CFG_SBITS'(1);
      cfg_dict    <= CFG_CBITS'(MAX_CLASSES);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        REG_CLASSES:    cfg_classes <= cfg_data;
        REG_STEPS:      cfg_steps   <= cfg_data[CFG_SBITS-1:0];
        REG_DICTIONARY: cfg_dict    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      class_counter  <= '0;
      step_counter   <= '0;
      top_score      <= '0;
      best_index     <= '0;
      previous_index <= '0;
      previous_valid <= 1'b0;
      score_sum      <= '0;
      emitted_count  <= '0;
      latched_tag    <= '0;
    end else if (accept) begin
      latched_tag <= tag_now;
      top_score   <= cur_score;
      best_index  <= cur_index;
      if (!step_end) begin
        class_counter <= class_counter + CLASS_BITS'(1);
      end else begin
        class_counter <= '0;
        if (seq_end) begin
          step_counter   <= '0;
          previous_index <= '0;
          previous_valid <= 1'b0;
          score_sum      <= '0;
          emitted_count  <= '0;
        end else begin
          step_counter   <= step_counter + STEP_BITS'(1);
          previous_index <= cur_index;
          previous_valid <= 1'b1;
          score_sum      <= sum_new;
          emitted_count  <= count_new;
        end
      end
    end
  end

  // divider loads magnitude of the final sum and iterates in ST_DIV
  always_ff @(posedge clk) begin
    if (rst) begin
      div_iter <= '0;
    end else if (accept && seq_end) begin
      div_quot <= sum_new[SUM_BITS-1] ? SUM_BITS'(-sum_new) : SUM_BITS'(sum_new);
      div_neg  <= sum_new[SUM_BITS-1];
      div_den  <= count_new;
      div_rem  <= '0;
      div_iter <= '0;
    end else if (state == ST_DIV) begin
      div_rem  <= rem_ge ? rem_diff[CFG_SBITS-1:0] : rem_shift[CFG_SBITS-1:0];
      div_quot <= {div_quot[SUM_BITS-2:0], rem_ge};
      div_iter <= div_iter + ITER_BITS'(1);
    end
  end

  // ---------------------------------------------------------------
  // result queue
  result_t                      push_item;
  logic                         push;
  logic                         pop;
  logic signed [SCORE_BITS-1:0] mean_val;

  always_comb begin
    // no tokens means a zero divisor; mean is defined as zero then
    if (div_den == '0)
      mean_val = '0;
    else if (div_neg)
      mean_val = -SCORE_BITS'(div_quot);
    else
      mean_val = SCORE_BITS'(div_quot);

    if (sum_push) begin
      push_item.kind        = KIND_SUMMARY;
      push_item.token_index = '0;
      push_item.tag         = latched_tag;
      push_item.mean        = mean_val;
      push_item.count       = div_den;
      push_item.last        = 1'b1;
    end else begin
      push_item.kind        = KIND_TOKEN;
      push_item.token_index = cur_index;
      push_item.tag         = tag_now;
      push_item.mean        = '0;
      push_item.count       = '0;
      push_item.last        = 1'b0;
    end
  end

  assign push = sum_push || (accept && keep);
  assign pop  = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (push) out_q[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      q_cnt <= q_cnt + 2'(push) - 2'(pop);
    end
  end

  assign result_valid    = (q_cnt != '0);
  assign kind            = out_q[rd_ptr].kind;
  assign token_index     = out_q[rd_ptr].token_index;
  assign tag_out         = out_q[rd_ptr].tag;
  assign mean_confidence = out_q[rd_ptr].mean;
  assign token_count     = out_q[rd_ptr].count;
  assign last            = out_q[rd_ptr].last;

  // ---------------------------------------------------------------
  // assertions
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= 2'd2)
    else $error("result queue overfilled");

  a_summary_queued: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |=> result_valid)
    else $error("summary cycle did not leave a result queued");

  a_token_nonblank: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (kind == KIND_TOKEN)) |-> (token_index != '0))
    else $error("blank class emitted as token");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    emitted_count <= {1'b0, step_counter})
    else $error("more tokens than completed steps");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench for ctc_greedy_decoder_core: directed and random score streams, with every
// token and summary checked against a greedy decoding predictor in this file.
// Depends on ctcg_pkg and the core RTL.
module tb;
  import ctcg_pkg::*;

  localparam int DRAIN_CYCLES = 40;  // division plus summary queueing, with margin
  localparam int MAX_PRINTS   = 40;

  typedef enum int {
    FLOW_FREE,
    FLOW_SRC_IDLE,
    FLOW_SINK_STALL,
    FLOW_BOTH
  } flow_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [1:0]                   cfg_index = '0;
  logic [CFG_DBITS-1:0]         cfg_data = '0;
  logic                         score_valid = 1'b0;
  logic                         score_ready;
  logic signed [SCORE_BITS-1:0] score = '0;
  logic [TAG_BITS-1:0]          sequence_tag = '0;
  logic                         result_valid;
  logic                         result_ready = 1'b0;
  logic                         kind;
  logic [CLASS_BITS-1:0]        token_index;
  logic [TAG_BITS-1:0]          tag_out;
  logic signed [SCORE_BITS-1:0] mean_confidence;
  logic [CFG_SBITS-1:0]         token_count;
  logic                         last;

  ctc_greedy_decoder_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .score_valid     (score_valid),
    .score_ready     (score_ready),
    .score           (score),
    .sequence_tag    (sequence_tag),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .kind            (kind),
    .token_index     (token_index),
    .tag_out         (tag_out),
    .mean_confidence (mean_confidence),
    .token_count     (token_count),
    .last            (last)
  );

  always #4 clk = ~clk;

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int scores_sent = 0;
  int tokens_checked = 0;
  int summaries_checked = 0;
  int reg_writes = 0;

  // decoder image: registers, counters, running totals
  logic [CFG_CBITS-1:0]         nclass_reg = CFG_CBITS'(1);
  logic [CFG_SBITS-1:0]         nstep_reg = CFG_SBITS'(1);
  logic [CFG_CBITS-1:0]         dict_reg = CFG_CBITS'(MAX_CLASSES);
  logic [CLASS_BITS-1:0]        cls_pos = '0;
  logic [STEP_BITS-1:0]         step_pos = '0;
  logic signed [SCORE_BITS-1:0] lead_score = '0;
  logic [CLASS_BITS-1:0]        best_cls = '0;
  logic [CLASS_BITS-1:0]        prev_cls = '0;
  logic                         prev_seen = 1'b0;
  logic signed [SUM_BITS-1:0]   score_acc = '0;
  logic [CFG_SBITS-1:0]         token_tally = '0;
  logic [TAG_BITS-1:0]          held_tag = '0;

  result_t decoded_q[$];
  result_t want;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    if (errors < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, exp);
    errors++;
  endtask

  task automatic decode_score(input logic signed [SCORE_BITS-1:0] s,
                              input logic [TAG_BITS-1:0] t);
    int unsigned n_cls;
    int unsigned n_stp;
    longint acc;
    result_t r;
    n_cls = (nclass_reg == 0) ? 1 : ((nclass_reg > MAX_CLASSES) ? MAX_CLASSES : nclass_reg);
    n_stp = (nstep_reg == 0) ? 1 : ((nstep_reg > MAX_STEPS) ? MAX_STEPS : nstep_reg);
    if (cls_pos == 0 && step_pos == 0) held_tag = t;
    if (cls_pos == 0) begin
      lead_score = s;
      best_cls = '0;
    end else if (s > lead_score) begin
      lead_score = s;
      best_cls = cls_pos;
    end
    if (cls_pos + 1 < n_cls) begin
      cls_pos = cls_pos + CLASS_BITS'(1);
      return;
    end
    cls_pos = '0;
    // blank, repeat of the previous winner and out-of-dictionary winners are dropped
    if (best_cls != 0 && !(prev_seen && best_cls == prev_cls) && best_cls < dict_reg) begin
      acc = longint'(score_acc) + longint'(lead_score);
      if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
      if (acc < longint'(SUM_MIN)) acc = longint'(SUM_MIN);
      score_acc = acc[SUM_BITS-1:0];
      token_tally = token_tally + CFG_SBITS'(1);
      r = '0;
      r.kind = KIND_TOKEN;
      r.token_index = best_cls;
      r.tag = held_tag;
      decoded_q.insert(decoded_q.size(), r);
    end
    prev_cls = best_cls;
    prev_seen = 1'b1;
    if (step_pos + 1 < n_stp) begin
      step_pos = step_pos + STEP_BITS'(1);
      return;
    end
    if (token_tally == 0) acc = 0;
    else acc = longint'(score_acc) / longint'(token_tally);
    r = '0;
    r.kind = KIND_SUMMARY;
    r.tag = held_tag;
    r.mean = acc[SCORE_BITS-1:0];
    r.count = token_tally;
    r.last = 1'b1;
    decoded_q.insert(decoded_q.size(), r);
    step_pos = '0;
    prev_cls = '0;
    prev_seen = 1'b0;
    score_acc = '0;
    token_tally = '0;
    lead_score = '0;
    best_cls = '0;
  endtask

  task automatic set_flow(input flow_t f);
    case (f)
      FLOW_FREE:       begin idle_pct = 0;  stall_pct = 0;  end
      FLOW_SRC_IDLE:   begin idle_pct = 62; stall_pct = 0;  end
      FLOW_SINK_STALL: begin idle_pct = 0;  stall_pct = 62; end
      default:         begin idle_pct = 7;  stall_pct = 7;  end
    endcase
  endtask

  // valid is only lowered on an idle cycle, so back-to-back transfers keep it high
  task automatic push_score(input logic signed [SCORE_BITS-1:0] s,
                            input logic [TAG_BITS-1:0] t);
    while ($urandom_range(99) < idle_pct) begin
      score_valid <= 1'b0;
      @(posedge clk);
    end
    score_valid <= 1'b1;
    score <= s;
    sequence_tag <= t;
    @(posedge clk);
    while (!score_ready) @(posedge clk);
    decode_score(s, t);
    scores_sent++;
  endtask

  task automatic settle();
    score_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DBITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CLASSES:    nclass_reg = val;
      REG_STEPS:      nstep_reg = val[CFG_SBITS-1:0];
      REG_DICTIONARY: dict_reg = val;
      default:        ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned c, input int unsigned s, input int unsigned d);
    settle();
    write_reg(REG_CLASSES, CFG_DBITS'(c));
    write_reg(REG_STEPS, CFG_DBITS'(s));
    write_reg(REG_DICTIONARY, CFG_DBITS'(d));
  endtask

  function automatic logic [TAG_BITS-1:0] rand_tag();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [SCORE_BITS-1:0] rand_score();
    int unsigned pick;
    logic [31:0] raw;
    pick = $urandom_range(99);
    raw = $urandom;
    if (pick < 40) return raw[SCORE_BITS-1:0];
    if (pick < 55) return raw[0] ? 16'sh7FFF : 16'sh8000;
    if (pick < 75) return SCORE_BITS'(int'($urandom_range(6)) - 3);  // ties
    return SCORE_BITS'(int'($urandom_range(2000)) - 1000);
  endfunction

  function automatic int unsigned pick_len(input int unsigned hi);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return 0;
    if (pick < 75) return $urandom_range(6, 1);
    return $urandom_range(hi, 7);
  endfunction

  // reset registers: every score is a one-class sequence, so class 0 wins and is blank
  task automatic test_defaults();
    set_flow(FLOW_FREE);
    push_score(16'sh7FFF, '1);
    push_score(16'sh8000, '0);
  endtask

  // repeat, blank, dictionary cut, tie and truncation of a negative mean
  task automatic test_token_rules();
    int sc[18];
    set_flow(FLOW_SINK_STALL);
    configure(3, 6, 2);
    sc = '{-200, -100, -300,      // class 1 emitted
           -32768, -50, -60,      // class 1 again: repeat
           32767, 100, 100,       // blank
           -500, -100, -400,      // class 1 after blank: emitted
           -9, -9, 5,             // class 2, outside the dictionary
           -700, -101, -101};     // tie, first wins: class 1 emitted
    for (int i = 0; i < 18; i++) push_score(SCORE_BITS'(sc[i]), rand_tag());
  endtask

  task automatic test_zero_lengths();
    set_flow(FLOW_SRC_IDLE);
    configure(0, 0, 16383);
    push_score(rand_score(), rand_tag());
    configure(2, 1, 0);
    push_score(-16'sd5, rand_tag());
    push_score(16'sd7, rand_tag());
    configure(2, 1, 16383);
    write_reg(REG_UNUSED, '1);
    push_score(-16'sd5, rand_tag());
    push_score(16'sd7, rand_tag());
  endtask

  // class count lowered below the position reached: the next score ends the step
  task automatic test_reconfig_mid_step();
    set_flow(FLOW_BOTH);
    configure(4, 2, MAX_CLASSES);
    push_score(16'sd5, rand_tag());
    push_score(16'sd9, rand_tag());
    push_score(16'sd1, rand_tag());
    settle();
    write_reg(REG_CLASSES, CFG_DBITS'(2));
    push_score(16'sd2, rand_tag());
    push_score(16'sd0, rand_tag());
    push_score(16'sd7, rand_tag());
  endtask

  // oversized step count saturates; one class per step, so only the summary's
  // position in the stream shows where the sequence closed
  task automatic test_longest_sequence();
    set_flow(FLOW_SINK_STALL);
    configure(1, 16383, 16383);
    for (int st = 0; st < MAX_STEPS; st++) push_score(rand_score(), rand_tag());
  endtask

  // rounds stop at a fixed count, so the next setting often lands mid sequence
  task automatic test_random_streams();
    int unsigned c;
    int unsigned s;
    int unsigned d;
    for (int round = 0; round < 8; round++) begin
      set_flow(flow_t'(round % 4));
      c = pick_len(40);
      s = pick_len(32);
      case ($urandom_range(7))
        0:       d = 0;
        1:       d = 1;
        2, 3:    d = $urandom_range(40, 2);
        4, 5:    d = MAX_CLASSES;
        6:       d = $urandom_range(16383);
        default: d = 16383;
      endcase
      configure(c, s, d);
      for (int i = 0; i < 120; i++) push_score(rand_score(), rand_tag());
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing expected", 64'({kind, token_index}), '0);
      end else begin
        want = decoded_q.pop_front();
        if (kind !== want.kind) report_mismatch("kind", 64'(kind), 64'(want.kind));
        if (token_index !== want.token_index)
          report_mismatch("token_index", 64'(token_index), 64'(want.token_index));
        if (tag_out !== want.tag) report_mismatch("tag_out", tag_out, want.tag);
        if (mean_confidence !== want.mean)
          report_mismatch("mean_confidence", 64'(unsigned'(mean_confidence)),
                          64'(unsigned'(want.mean)));
        if (token_count !== want.count)
          report_mismatch("token_count", 64'(token_count), 64'(want.count));
        if (last !== want.last) report_mismatch("last", 64'(last), 64'(want.last));
        if (want.kind == KIND_TOKEN) tokens_checked++;
        else summaries_checked++;
      end
    end
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_token_rules();
    test_zero_lengths();
    test_reconfig_mid_step();
    test_longest_sequence();
    test_random_streams();
    settle();
    $display("%0d scores sent, %0d register writes; %0d tokens and %0d summaries compared",
             scores_sent, reg_writes, tokens_checked, summaries_checked);
    if (errors == 0) begin
      $display("ctc_greedy_decoder_core test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("ctc_greedy_decoder_core test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", decoded_q.size());
    $display("ctc_greedy_decoder_core test failed");
    $finish;
  end

endmodule
